[hdl/clnf_pkg.sv]
// Shared types, request codes and constant tables for the character LCD nibble framer.
package clnf_pkg;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned FRAME_W  = 8;
	localparam int unsigned WAIT_W   = 4;

	localparam logic [ACTION_W-1:0] ACT_INIT  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CMD   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_DATA  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_GOTO  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

	localparam logic [7:0] EN_BIT      = 8'h08;
	localparam logic [7:0] RS_BIT      = 8'h04;
	localparam logic [7:0] EN_CLR_MASK = 8'hF7;
	localparam logic [7:0] RS_CLR_MASK = 8'hFB;
	localparam logic [7:0] LOW_MASK    = 8'h0F;
	localparam logic [7:0] OPEN_FRAME  = 8'h08;

	localparam logic [3:0] NIB_WAKE = 4'h3;
	localparam logic [3:0] NIB_4BIT = 4'h2;

	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [1:0] DDRAM_SET    = 2'b10;

	localparam logic [WAIT_W-1:0] WAIT_NONE   = 4'd0;
	localparam logic [WAIT_W-1:0] WAIT_STROBE = 4'd1;
	localparam logic [WAIT_W-1:0] WAIT_OPEN   = 4'd10;

	// Segment numbering of an init run: opening frame, four wake-up nibbles, four commands.
	localparam logic [3:0] SEG_LAST_WAKE = 4'd4;
	localparam logic [3:0] SEG_FIRST_CMD = 4'd5;
	localparam logic [3:0] SEG_INIT_END  = 4'd8;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_OPEN,
		OP_NIB,
		OP_BYTE
	} op_t;

	typedef struct packed {
		logic       is_init;
		logic       two_bytes;
		logic       rs;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} req_t;

	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = CMD_FUNC_SET;
			2'd1: r = CMD_DISP_ON;
			2'd2: r = CMD_CLEAR;
			default: r = CMD_ENTRY;
		endcase
		return r;
	endfunction

endpackage

[hdl/clnf_front.sv]
// Front end: accepts requests and classifies them into queue entries.
module clnf_front (
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [15:0]              s_tdata,
	input  logic [2:0]               s_tuser,
	input  logic                     queue_full,
	output logic                     push,
	output clnf_pkg::req_t           push_req
);
	import clnf_pkg::*;

	logic [7:0] value;
	logic [5:0] column;
	logic       row;
	logic       known;

	assign value  = s_tdata[7:0];
	assign column = s_tdata[13:8];
	assign row    = s_tdata[14];

	always_comb begin
		push_req = '0;
		known    = 1'b1;
		unique case (s_tuser)
			ACT_INIT: begin
				push_req.is_init = 1'b1;
			end
			ACT_CMD: begin
				push_req.byte0 = value;
			end
			ACT_DATA: begin
				push_req.rs    = 1'b1;
				push_req.byte0 = value;
			end
			ACT_GOTO: begin
				push_req.byte0 = {DDRAM_SET[1], row, column};
			end
			ACT_CLEAR: begin
				push_req.two_bytes = 1'b1;
				push_req.byte0     = CMD_CLEAR;
				push_req.byte1     = CMD_HOME;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Unknown requests are taken and dropped without producing frames.
	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full && known;

endmodule

[hdl/clnf_queue.sv]
// Short queue of classified requests between the front end and the sequencer.
module clnf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clnf_pkg::req_t push_req,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output clnf_pkg::req_t head
);
	import clnf_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	req_t               mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/clnf_back.sv]
// Back end: expands queued requests into latch frames and holds the shadow frame.
module clnf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  clnf_pkg::req_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,
	output logic           m_tlast
);
	import clnf_pkg::*;

	req_t       cur_q;
	logic       busy_q;
	logic [3:0] seg_q;
	logic [2:0] step_q;
	logic [7:0] shadow_q;

	logic       out_valid_q;
	logic [7:0] frame_q;
	logic [3:0] wait_q;
	logic       last_q;

	op_t        op;
	logic [3:0] nib_code;
	logic [7:0] cur_byte;
	logic       cur_rs;
	logic [2:0] last_step;
	logic       seg_done;
	logic       run_done;
	logic [7:0] next_frame;
	logic [3:0] next_wait;
	logic       out_free;
	logic       advance;

	always_comb begin
		op       = OP_BYTE;
		nib_code = NIB_WAKE;
		cur_byte = cur_q.byte0;
		cur_rs   = cur_q.rs;
		if (cur_q.is_init) begin
			cur_rs = 1'b0;
			if (seg_q == '0) begin
				op = OP_OPEN;
			end else if (seg_q <= SEG_LAST_WAKE) begin
				op       = OP_NIB;
				nib_code = (seg_q == SEG_LAST_WAKE) ? NIB_4BIT : NIB_WAKE;
			end else begin
				cur_byte = init_cmd(2'(seg_q - SEG_FIRST_CMD));
			end
		end else if (seg_q[0]) begin
			cur_byte = cur_q.byte1;
		end
	end

	always_comb begin
		next_frame = shadow_q;
		next_wait  = WAIT_NONE;
		last_step  = 3'd6;
		unique case (op)
			OP_OPEN: begin
				last_step  = 3'd0;
				next_frame = OPEN_FRAME;
				next_wait  = WAIT_OPEN;
			end
			OP_NIB: begin
				last_step = 3'd2;
				case (step_q)
					3'd0: next_frame = {nib_code, 4'h0};
					3'd1: begin
						next_frame = shadow_q | EN_BIT;
						next_wait  = WAIT_STROBE;
					end
					default: begin
						next_frame = shadow_q & EN_CLR_MASK;
						next_wait  = WAIT_STROBE;
					end
				endcase
			end
			default: begin
				case (step_q)
					3'd0: next_frame = cur_rs ? (shadow_q | RS_BIT) : (shadow_q & RS_CLR_MASK);
					3'd1: next_frame = {cur_byte[7:4], shadow_q[3:0]};
					3'd4: next_frame = {cur_byte[3:0], shadow_q[3:0]};
					3'd2, 3'd5: begin
						next_frame = shadow_q | EN_BIT;
						next_wait  = WAIT_STROBE;
					end
					default: begin
						next_frame = shadow_q & EN_CLR_MASK;
						next_wait  = WAIT_STROBE;
					end
				endcase
			end
		endcase
	end

	assign seg_done = (step_q == last_step);
	assign run_done = seg_done && (cur_q.is_init ? (seg_q == SEG_INIT_END)
		: (cur_q.two_bytes ? (seg_q == 4'd1) : (seg_q == 4'd0)));

	assign out_free = !out_valid_q || m_tready;
	assign advance  = busy_q && out_free;
	assign pop      = not_empty && (!busy_q || (advance && run_done));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			frame_q <= next_frame;
			wait_q  <= next_wait;
			last_q  <= run_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			seg_q       <= '0;
			step_q      <= '0;
			shadow_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				shadow_q <= next_frame;
				if (seg_done) begin
					step_q <= '0;
					seg_q  <= run_done ? 4'd0 : seg_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && run_done) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, wait_q, frame_q};
	assign m_tlast  = last_q;

endmodule

[hdl/char_lcd_nibble_framer.sv]
// Top level of the character LCD nibble framer.
//
// Each request on the slave channel (tuser carries the action, tdata the byte,
// column and row) is turned into the run of latch frames for a display driven
// in 4-bit mode. Every frame leaves on the master channel with its wait count,
// and tlast marks the final frame of a request's run.
// A command, data or goto request yields seven frames, clear and home fourteen
// and init forty-one; unknown actions are taken and yield none.
// The sequencer emits one frame per cycle unless the receiver stalls, and runs
// of queued requests follow each other without gaps. A request taken passes
// the queue and the request register before its first frame is registered.
// A two-entry request queue lets the slave side take further requests while
// the sequencer is still busy; tready falls only when that queue is full.
// When the receiver stalls, the current frame is held in the output register
// and the sequencer waits with it.
// Reset empties the queue, stops any run in progress and clears the shadow
// frame to zero.
module char_lcd_nibble_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // value[7:0], column[13:8], row[14], zero[15]
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // frame[7:0], wait_units[11:8], zero[15:12]
	output logic        m_tlast
);
	import clnf_pkg::*;

	logic queue_full;
	logic push;
	req_t push_req;
	logic pop;
	logic not_empty;
	req_t head;

	clnf_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.push_req   (push_req)
	);

	clnf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	clnf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

[tb/tb_char_lcd_nibble_framer.sv]
// Self-checking testbench for the character LCD nibble framer with a predictor of its frame runs.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_framer;
	import clnf_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACT_CLEAR + 3'd1;
	localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = '1;
	localparam int unsigned RANDOM_REQS   = 450;
	localparam int unsigned IDLE_PERCENT  = 13;
	localparam int unsigned QUIET_FROM    = 1500;
	localparam int unsigned QUIET_TO      = 3000;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES  = 20;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [7:0]          value;
		logic [5:0]          column;
		logic                row;
	} lcd_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [WAIT_W-1:0]  wait_units;
		logic               last;
	} latch_frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	lcd_req_t     pending_reqs[$];
	latch_frame_t expected_frames[$];
	lcd_req_t     next_req;
	latch_frame_t got_frame;
	logic [7:0]   latch_shadow = '0;
	int unsigned  cycle_count = 0;
	int unsigned  stall_count = 0;
	int unsigned  error_count = 0;

	char_lcd_nibble_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit take_break();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PERCENT;
	endfunction

	function automatic void latch_frame(input logic [WAIT_W-1:0] wait_units);
		latch_frame_t f;
		f.frame      = latch_shadow;
		f.wait_units = wait_units;
		f.last       = 1'b0;
		expected_frames.push_back(f);
	endfunction

	function automatic void pulse_enable();
		latch_shadow = latch_shadow | EN_BIT;
		latch_frame(WAIT_STROBE);
		latch_shadow = latch_shadow & EN_CLR_MASK;
		latch_frame(WAIT_STROBE);
	endfunction

	function automatic void write_nibble(input logic [3:0] nib);
		latch_shadow = (latch_shadow & LOW_MASK) | {nib, 4'h0};
		latch_frame(WAIT_NONE);
		pulse_enable();
	endfunction

	function automatic void write_byte(input logic is_data, input logic [7:0] b);
		latch_shadow = is_data ? (latch_shadow | RS_BIT) : (latch_shadow & RS_CLR_MASK);
		latch_frame(WAIT_NONE);
		write_nibble(b[7:4]);
		write_nibble(b[3:0]);
	endfunction

	function automatic void predict_run(input logic [ACTION_W-1:0] action,
			input logic [7:0] value, input logic [5:0] column, input logic row);
		int unsigned  before_count;
		latch_frame_t tail;
		before_count = expected_frames.size();
		case (action)
			ACT_INIT: begin
				latch_shadow = OPEN_FRAME;
				latch_frame(WAIT_OPEN);
				for (int i = 0; i < 3; i++) begin
					latch_shadow = {NIB_WAKE, 4'h0};
					latch_frame(WAIT_NONE);
					pulse_enable();
				end
				latch_shadow = {NIB_4BIT, 4'h0};
				latch_frame(WAIT_NONE);
				pulse_enable();
				write_byte(1'b0, CMD_FUNC_SET);
				write_byte(1'b0, CMD_DISP_ON);
				write_byte(1'b0, CMD_CLEAR);
				write_byte(1'b0, CMD_ENTRY);
			end
			ACT_CMD:   write_byte(1'b0, value);
			ACT_DATA:  write_byte(1'b1, value);
			ACT_GOTO:  write_byte(1'b0, {1'b1, row, column});
			ACT_CLEAR: begin
				write_byte(1'b0, CMD_CLEAR);
				write_byte(1'b0, CMD_HOME);
			end
			default: ;
		endcase
		if (expected_frames.size() > before_count) begin
			tail = expected_frames.pop_back();
			tail.last = 1'b1;
			expected_frames.push_back(tail);
		end
	endfunction

	function automatic void add_req(input logic [ACTION_W-1:0] action,
			input logic [7:0] value, input logic [5:0] column, input logic row);
		lcd_req_t r;
		r.action = action;
		r.value  = value;
		r.column = column;
		r.row    = row;
		pending_reqs.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			latch_shadow = '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_run(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[14]);
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && !take_break()) begin
					next_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_req.action;
					s_tdata <= {1'b0, next_req.row, next_req.column, next_req.value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected frame: frame %h wait_units %0d last %0b",
						m_tdata[7:0], m_tdata[11:8], m_tlast);
					error_count++;
				end else begin
					got_frame = expected_frames.pop_front();
					if (m_tdata[7:0] !== got_frame.frame) begin
						$error("frame: expected %h, got %h", got_frame.frame, m_tdata[7:0]);
						error_count++;
					end
					if (m_tdata[11:8] !== got_frame.wait_units) begin
						$error("wait_units: expected %0d, got %0d",
							got_frame.wait_units, m_tdata[11:8]);
						error_count++;
					end
					if (m_tlast !== got_frame.last) begin
						$error("last: expected %0b, got %0b", got_frame.last, m_tlast);
						error_count++;
					end
				end
			end
			m_tready <= !take_break();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("FAIL char_lcd_nibble_framer");
			$finish;
		end
	end

	initial begin
		int unsigned counted;
		int unsigned pick;
		// Requests ahead of init see the shadow frame straight out of reset.
		add_req(ACT_DATA, 8'h3C, 6'd0, 1'b0);
		add_req(ACT_CMD, 8'h00, 6'd0, 1'b0);
		add_req(ACT_INIT, 8'h00, 6'd0, 1'b0);
		add_req(ACT_CMD, 8'hFF, 6'h3F, 1'b1);
		add_req(ACT_DATA, 8'h00, 6'd0, 1'b0);
		add_req(ACT_DATA, 8'hFF, 6'h3F, 1'b1);
		add_req(ACT_GOTO, 8'h00, 6'd0, 1'b0);
		add_req(ACT_GOTO, 8'hFF, 6'h3F, 1'b0);
		add_req(ACT_GOTO, 8'h00, 6'd0, 1'b1);
		add_req(ACT_GOTO, 8'hFF, 6'h3F, 1'b1);
		add_req(ACT_DATA, 8'hA5, 6'h2A, 1'b0);
		add_req(ACT_CLEAR, 8'hFF, 6'h3F, 1'b1);
		add_req(ACT_FIRST_UNUSED, 8'hFF, 6'h3F, 1'b1);
		add_req(ACT_FIRST_UNUSED + 3'd1, 8'h55, 6'h15, 1'b0);
		add_req(ACT_LAST_UNUSED, 8'hAA, 6'h2A, 1'b1);
		add_req(ACT_CMD, 8'h5A, 6'h15, 1'b0);
		add_req(ACT_DATA, 8'h7E, 6'd1, 1'b1);
		add_req(ACT_INIT, 8'hFF, 6'h3F, 1'b1);
		add_req(ACT_DATA, 8'h81, 6'd0, 1'b0);
		counted = 0;
		while (counted < RANDOM_REQS) begin
			pick = $urandom_range(99);
			if (pick < 5)
				add_req(ACT_INIT, 8'($urandom), 6'($urandom), 1'($urandom));
			else if (pick < 30)
				add_req(ACT_CMD, 8'($urandom), 6'($urandom), 1'($urandom));
			else if (pick < 65)
				add_req(ACT_DATA, 8'($urandom), 6'($urandom), 1'($urandom));
			else if (pick < 85)
				add_req(ACT_GOTO, 8'($urandom), 6'($urandom), 1'($urandom));
			else if (pick < 95)
				add_req(ACT_CLEAR, 8'($urandom), 6'($urandom), 1'($urandom));
			else
				add_req(3'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED)),
					8'($urandom), 6'($urandom), 1'($urandom));
			counted++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_frames.size() != 0) begin
			$error("%0d expected frames never arrived", expected_frames.size());
			error_count++;
		end
		if (error_count == 0)
			$display("PASS char_lcd_nibble_framer");
		else
			$display("FAIL char_lcd_nibble_framer");
		$finish;
	end

endmodule

[filelist.f]
hdl/clnf_pkg.sv
hdl/clnf_front.sv
hdl/clnf_queue.sv
hdl/clnf_back.sv
hdl/char_lcd_nibble_framer.sv
tb/tb_char_lcd_nibble_framer.sv
